### rtl/nsv_pkg.sv
// ----------------------------------------------------------------------------
// nsv_pkg
// Shared types, character codes and helper functions for the NMEA sentence
// validator.
// ----------------------------------------------------------------------------
`default_nettype none

package nsv_pkg;

    // syntax position inside one token
    typedef enum logic [3:0] {
        PH_DOLLAR = 4'd0,
        PH_G      = 4'd1,
        PH_P      = 4'd2,
        PH_TYPE0  = 4'd3,
        PH_TYPE1  = 4'd4,
        PH_TYPE2  = 4'd5,
        PH_COMMA  = 4'd6,
        PH_BODY   = 4'd7,
        PH_HEX0   = 4'd8,
        PH_HEX1   = 4'd9,
        PH_DONE   = 4'd10
    } phase_t;

    // reported sentence kinds
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_GLL  = 2'd1,
        KIND_GGA  = 2'd2,
        KIND_RMC  = 2'd3
    } kind_t;

    // ascii codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;

    // three-letter sentence types, first letter in the top byte
    localparam logic [23:0] TYPE_GLL = 24'h474C4C;
    localparam logic [23:0] TYPE_GGA = 24'h474741;
    localparam logic [23:0] TYPE_RMC = 24'h524D43;

    // expected field totals per type
    localparam logic [5:0] FIELDS_GLL = 6'd5;
    localparam logic [5:0] FIELDS_GGA = 6'd14;
    localparam logic [5:0] FIELDS_RMC = 6'd11;
    localparam logic [5:0] FIELDS_MAX = 6'd63;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_body_char(input logic [7:0] c);
        return is_upper(c) || is_lower(c) || is_digit(c) ||
               (c == CH_DASH) || (c == CH_COMMA) || (c == CH_DOT);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    // nibble value of a hex digit, only meaningful when is_hex holds
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (is_digit(c))
        begin
            v = c - 8'h30;
        end
        else if (c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        else
        begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

### rtl/nmea_sentence_validator_top.sv
// A character is first taken into the input register, and the result of a last
// character is then loaded into the result register when the output is free.
// Throughput: one character per cycle, set by the single-pass phase update.
// A result waiting on result_stall holds back the input only for a last character.
// Reset: asynchronous, active low; clears phase, checks and both valid bits.
// ----------------------------------------------------------------------------
// nmea_sentence_validator_top
// Checks NMEA 0183 sentences one character at a time: syntax, XOR checksum,
// sentence type and field count, with one result per token.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_validator_top
    import nsv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       char_valid,
    output logic            char_stall,
    input  wire logic [7:0] char_code,
    input  wire logic       token_end,

    output logic            result_valid,
    input  wire logic       result_stall,
    output logic            well_formed,
    output logic            checksum_good,
    output logic [1:0]      sentence_kind,
    output logic [5:0]      field_total,
    output logic            accepted
);

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_end_reg;

    // token state
    phase_t      phase_reg, phase_next;
    logic        err_reg, err_next;
    logic [23:0] letters_reg, letters_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  csum_reg, csum_next;
    logic [5:0]  count_reg, count_next;

    // result register
    logic        res_valid_reg;
    logic        wf_reg, ck_reg, acc_reg;
    kind_t       kind_reg;
    logic [5:0]  total_reg;

    // result of the current character
    logic        wf_c, ck_c, acc_c;
    kind_t       kind_c;
    logic [5:0]  total_c, want_c;

    logic        out_free;
    logic        advance;
    logic        load_result;

    // handshake control
    assign out_free    = !res_valid_reg || !result_stall;
    assign advance     = in_valid_reg && (!in_end_reg || out_free);
    assign load_result = advance && in_end_reg;
    assign char_stall  = in_valid_reg && !advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            in_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            in_char_reg <= char_code;
            in_end_reg  <= token_end;
        end
    end

    // next phase and sticky error
    always_comb
    begin
        phase_next = phase_reg;
        err_next   = err_reg;
        if (!err_reg)
        begin
            unique case (phase_reg)
                PH_DOLLAR:
                begin
                    if (in_char_reg == CH_DOLLAR) phase_next = PH_G;
                    else                          err_next   = 1'b1;
                end
                PH_G:
                begin
                    if (in_char_reg == CH_G) phase_next = PH_P;
                    else                     err_next   = 1'b1;
                end
                PH_P:
                begin
                    if (in_char_reg == CH_P) phase_next = PH_TYPE0;
                    else                     err_next   = 1'b1;
                end
                PH_TYPE0:
                begin
                    if (is_upper(in_char_reg)) phase_next = PH_TYPE1;
                    else                       err_next   = 1'b1;
                end
                PH_TYPE1:
                begin
                    if (is_upper(in_char_reg)) phase_next = PH_TYPE2;
                    else                       err_next   = 1'b1;
                end
                PH_TYPE2:
                begin
                    if (is_upper(in_char_reg)) phase_next = PH_COMMA;
                    else                       err_next   = 1'b1;
                end
                PH_COMMA:
                begin
                    if (in_char_reg == CH_COMMA) phase_next = PH_BODY;
                    else                         err_next   = 1'b1;
                end
                PH_BODY:
                begin
                    if (in_char_reg == CH_STAR)          phase_next = PH_HEX0;
                    else if (!is_body_char(in_char_reg)) err_next   = 1'b1;
                end
                PH_HEX0:
                begin
                    if (is_hex(in_char_reg)) phase_next = PH_HEX1;
                    else                     err_next   = 1'b1;
                end
                PH_HEX1:
                begin
                    if (is_hex(in_char_reg)) phase_next = PH_DONE;
                    else                     err_next   = 1'b1;
                end
                default:
                begin
                    err_next = 1'b1;
                end
            endcase
        end
    end

    // datapath updates: type letters, xor, checksum digits, field count
    always_comb
    begin
        letters_next = letters_reg;
        xor_next     = xor_reg;
        csum_next    = csum_reg;
        count_next   = count_reg;
        if (!err_reg)
        begin
            if ((phase_reg != PH_DOLLAR) && (phase_reg <= PH_BODY) &&
                (in_char_reg != CH_STAR))
            begin
                xor_next = xor_reg ^ in_char_reg;
            end
            case (phase_reg)
                PH_TYPE0, PH_TYPE1, PH_TYPE2:
                begin
                    if (is_upper(in_char_reg))
                    begin
                        letters_next = {letters_reg[15:0], in_char_reg};
                    end
                end
                PH_COMMA:
                begin
                    if (in_char_reg == CH_COMMA) count_next = 6'd1;
                end
                PH_BODY:
                begin
                    if ((in_char_reg == CH_COMMA) && (count_reg != FIELDS_MAX))
                    begin
                        count_next = count_reg + 6'd1;
                    end
                end
                PH_HEX0, PH_HEX1:
                begin
                    if (is_hex(in_char_reg))
                    begin
                        csum_next = {csum_reg[3:0], hex_value(in_char_reg)};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // token result from the updated state
    always_comb
    begin
        wf_c    = !err_next && (phase_next == PH_DONE);
        ck_c    = wf_c && (xor_next == csum_next);
        kind_c  = KIND_NONE;
        want_c  = 6'd0;
        total_c = 6'd0;
        if (wf_c)
        begin
            total_c = count_next;
            if (letters_next == TYPE_GLL)
            begin
                kind_c = KIND_GLL;
                want_c = FIELDS_GLL;
            end
            else if (letters_next == TYPE_GGA)
            begin
                kind_c = KIND_GGA;
                want_c = FIELDS_GGA;
            end
            else if (letters_next == TYPE_RMC)
            begin
                kind_c = KIND_RMC;
                want_c = FIELDS_RMC;
            end
        end
        acc_c = ck_c && (kind_c != KIND_NONE) && (total_c == want_c);
    end

    // token state registers, cleared at the end of every token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_DOLLAR;
            err_reg     <= 1'b0;
            letters_reg <= 24'd0;
            xor_reg     <= 8'd0;
            csum_reg    <= 8'd0;
            count_reg   <= 6'd0;
        end
        else if (advance)
        begin
            if (in_end_reg)
            begin
                phase_reg   <= PH_DOLLAR;
                err_reg     <= 1'b0;
                letters_reg <= 24'd0;
                xor_reg     <= 8'd0;
                csum_reg    <= 8'd0;
                count_reg   <= 6'd0;
            end
            else
            begin
                phase_reg   <= phase_next;
                err_reg     <= err_next;
                letters_reg <= letters_next;
                xor_reg     <= xor_next;
                csum_reg    <= csum_next;
                count_reg   <= count_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            wf_reg    <= wf_c;
            ck_reg    <= ck_c;
            kind_reg  <= kind_c;
            total_reg <= total_c;
            acc_reg   <= acc_c;
        end
    end

    // outputs
    assign result_valid  = res_valid_reg;
    assign well_formed   = wf_reg;
    assign checksum_good = ck_reg;
    assign sentence_kind = kind_reg;
    assign field_total   = total_reg;
    assign accepted      = acc_reg;

endmodule

`default_nettype wire
